### rtl/u64da_pkg.sv
// Shared constants and types for the 64-bit binary to decimal ASCII converter.
package u64da_pkg;

	localparam int BIN_W      = 64;
	localparam int NUM_DIGITS = 20;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int CHAR_W     = 6;
	localparam int TDATA_O_W  = 8;
	localparam int STEP_W     = $clog2(BIN_W);
	localparam int IDX_W      = $clog2(NUM_DIGITS);

	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'h30;
	localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(NUM_DIGITS - 1);
	localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(BIN_W - 1);

	typedef logic [BCD_W-1:0]   bcd_t;
	typedef logic [DIGIT_W-1:0] digit_t;

	// Handshake between the top level and the conversion engine.
	typedef struct packed {
		logic busy;
		logic done;
	} dabble_status_t;

endpackage

### rtl/u64da_dabble.sv
// Shift-and-add-3 engine that turns a 64-bit binary value into 20 BCD digits, one bit a cycle.
module u64da_dabble
	import u64da_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [BIN_W-1:0] value,
	output dabble_status_t   status,
	output bcd_t             bcd
);

	logic [BIN_W-1:0]  bin_q;
	bcd_t              bcd_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	bcd_t              bcd_adj;

	// Every digit of 5 or more gets 3 added before the next shift.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= digit_t'(5)) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + digit_t'(3);
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// Control: step counter and busy/done flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == LAST_STEP);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: one binary bit moves into the BCD word each step.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign bcd         = bcd_q;

endmodule

### rtl/uint64_to_decimal_ascii.sv
// Top level of the unsigned 64-bit binary to decimal ASCII converter.
//
// Input channel s_*: one item is one 64-bit unsigned value in s_tdata.
// Output channel m_*: one item per decimal digit, most significant first,
// as an ASCII code '0'..'9' in m_tdata[5:0]; m_tlast marks the final digit.
// Leading zeros are dropped, and a zero value gives the single digit '0'.
// One to twenty output items follow each input item.
//
// Timing: after an input item is accepted the shift-and-add-3 engine
// shifts in all 64 bits, one binary bit per cycle. The 20 BCD digits are
// then scanned one per cycle, leading zeros skipped without output, so
// the digits follow one per cycle while the receiver keeps m_tready high.
// s_tready is high only while no conversion or digit run is in progress;
// the next value is taken as soon as the final digit sits in the output
// register, even if the receiver has not yet taken it.
// When the receiver holds m_tready low the output register keeps its digit
// and the scan waits at the next digit to send; leading zeros are still
// skipped meanwhile. Reset clears all control state; no item is pending.
module uint64_to_decimal_ascii
	import u64da_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [BIN_W-1:0]     s_tdata,   // [63:0] value
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_O_W-1:0] m_tdata,   // [5:0] digit_char, [7:6] zero
	output logic                 m_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	bcd_t              digits_q;
	logic [IDX_W-1:0]  idx_q;
	logic              lead_q;
	logic              m_tvalid_q;
	logic [CHAR_W-1:0] char_q;
	logic              tlast_q;

	dabble_status_t    dab_status;
	bcd_t              dab_bcd;
	logic              in_fire;
	logic              out_free;
	digit_t            top_digit;
	logic              is_last;
	logic              skip;
	logic              emit;

	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign top_digit = digits_q[BCD_W-1 -: DIGIT_W];
	assign is_last   = (idx_q == LAST_IDX);
	assign skip      = lead_q && (top_digit == '0) && !is_last;
	assign emit      = (state_q == ST_EMIT) && !skip && out_free;

	u64da_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.value  (s_tdata),
		.status (dab_status),
		.bcd    (dab_bcd)
	);

	// Sequencer: convert, then scan digits out of the BCD word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			lead_q     <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (dab_status.done) begin
						state_q <= ST_EMIT;
						idx_q   <= '0;
						lead_q  <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (skip) begin
						idx_q <= idx_q + IDX_W'(1);
					end else if (out_free) begin
						lead_q     <= 1'b0;
						idx_q      <= idx_q + IDX_W'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digit word and output payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_CONV && dab_status.done) begin
			digits_q <= dab_bcd;
		end else if (state_q == ST_EMIT && (skip || out_free)) begin
			digits_q <= {digits_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
		if (state_q == ST_EMIT && !skip && out_free) begin
			char_q  <= ASCII_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
			tlast_q <= is_last;
		end
	end

	assign s_tready = (state_q == ST_IDLE) && !dab_status.busy;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(TDATA_O_W-CHAR_W){1'b0}}, char_q};
	assign m_tlast  = tlast_q;

endmodule

### rtl/u64da_checker.sv
// Port-level checks for the decimal ASCII converter, bound to its top level.
module u64da_checker
	import u64da_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [TDATA_O_W-1:0] m_tdata,
	input logic                 m_tlast
);

	// A stalled output item holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// Every output item is an ASCII decimal digit.
	a_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:4] == 4'h3 && m_tdata[3:0] <= 4'd9)
		else $error("output item is not a decimal digit");

	// An accepted value makes the block busy for the conversion.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after an accept");

	// No new value is taken while a digit run is still unfinished.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready in the middle of a digit run");

endmodule

bind uint64_to_decimal_ascii u64da_checker u_u64da_checker (.*);

### tb/uint64_to_decimal_ascii_tb.sv
// Testbench for the 64-bit binary to decimal ASCII converter with a digit scoreboard.
`timescale 1ns / 100ps

module uint64_to_decimal_ascii_tb;
	import u64da_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_VALUES  = 108;
	localparam int CALM_TAIL      = 15;
	localparam int DRAIN_CYCLES   = 120;

	// One expected output item: a digit character and its last flag.
	typedef struct {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
	} digit_item_t;

	// Holds the digit characters still owed by the converter and checks arrivals.
	class digit_scoreboard;
		digit_item_t pending_digits[$];
		int          errors;
		int          values_noted;
		int          twenty_digit_values;
		int          digits_checked;

		function new();
			errors = 0;
			values_noted = 0;
			twenty_digit_values = 0;
			digits_checked = 0;
		endfunction

		// Splits the value into decimal digits and queues them from the first nonzero one.
		function void note_value(logic [BIN_W-1:0] value);
			logic [BIN_W-1:0] rest;
			digit_t           digits[NUM_DIGITS];
			int               first;
			bit               found;
			digit_item_t      item;
			rest = value;
			for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
				digits[i] = digit_t'(rest % 64'd10);
				rest = rest / 64'd10;
			end
			// A zero value still owes its final digit.
			first = NUM_DIGITS - 1;
			found = 1'b0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				if (!found && digits[i] != 0) begin
					first = i;
					found = 1'b1;
				end
			end
			for (int i = first; i < NUM_DIGITS; i++) begin
				item.digit_char = ASCII_ZERO + CHAR_W'(digits[i]);
				item.last = (i == NUM_DIGITS - 1);
				pending_digits.push_back(item);
			end
			values_noted++;
			if (first == 0)
				twenty_digit_values++;
		endfunction

		// Compares one accepted output item against the oldest expected digit.
		function void check_digit(logic [TDATA_O_W-1:0] tdata, logic tlast);
			digit_item_t want;
			logic [TDATA_O_W-CHAR_W-1:0] pad;
			digits_checked++;
			if (pending_digits.size() == 0) begin
				$error("digit item with nothing expected: tdata=%h tlast=%b", tdata, tlast);
				errors++;
				return;
			end
			want = pending_digits.pop_front();
			pad = tdata[TDATA_O_W-1:CHAR_W];
			if (tdata[CHAR_W-1:0] !== want.digit_char) begin
				$error("digit_char: expected %h, actual %h", want.digit_char, tdata[CHAR_W-1:0]);
				errors++;
			end
			if (pad !== '0) begin
				$error("tdata padding: expected %h, actual %h", {(TDATA_O_W-CHAR_W){1'b0}}, pad);
				errors++;
			end
			if (tlast !== want.last) begin
				$error("last: expected %b, actual %b", want.last, tlast);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [BIN_W-1:0]     s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_O_W-1:0] m_tdata;
	logic                 m_tlast;

	digit_scoreboard sb;
	bit              calm_phase = 1'b0;
	int              stall_left = 0;
	int              idle_cycles = 0;

	uint64_to_decimal_ascii u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Power of ten for exponents up to 19.
	function automatic logic [BIN_W-1:0] pow10(int n);
		logic [BIN_W-1:0] p;
		p = 64'd1;
		for (int i = 0; i < n; i++)
			p = p * 64'd10;
		return p;
	endfunction

	// Offers one value, optionally after an idle burst, and waits until it is taken.
	task automatic send_value(input logic [BIN_W-1:0] value);
		int gap;
		if (!calm_phase && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 18);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_value(value);
	endtask

	// Receiver: ready most of the time, with stall bursts of random length.
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!calm_phase && $urandom_range(0, 11) == 0) begin
				m_tready <= 1'b0;
				stall_left <= $urandom_range(0, 17);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Every accepted digit item goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_digit(m_tdata, m_tlast);
	end

	// Ends the run when no item moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [BIN_W-1:0] directed[] = '{
			64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd255,
			64'd4294967295, 64'd4294967296, 64'd999999999999999999,
			64'd1000000000000000000, 64'd9999999999999999999,
			64'd10000000000000000000, 64'd10000000000000000001,
			64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
			64'd12345678901234567890, 64'hffff_ffff_ffff_ffff,
			64'hffff_ffff_ffff_fffe, 64'h5555_5555_5555_5555,
			64'haaaa_aaaa_aaaa_aaaa, 64'd0
		};
		logic [BIN_W-1:0] value;
		logic [BIN_W-1:0] lo;
		logic [BIN_W-1:0] span;
		logic [BIN_W-1:0] raw;
		int               pick;
		int               ndigits;

		sb = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Extremes, powers of ten and their neighbors, zero before and after the largest value.
		foreach (directed[i])
			send_value(directed[i]);

		// Random values: full-range words, values of a chosen length, values near powers of ten.
		for (int n = 0; n < RANDOM_VALUES; n++) begin
			if (n == RANDOM_VALUES - CALM_TAIL)
				calm_phase = 1'b1;
			pick = $urandom_range(0, 99);
			raw = {$urandom, $urandom};
			if (pick < 25) begin
				value = raw;
			end else if (pick < 85) begin
				ndigits = $urandom_range(1, NUM_DIGITS);
				lo = (ndigits == 1) ? '0 : pow10(ndigits - 1);
				span = (ndigits == NUM_DIGITS) ? (~lo + 64'd1) : (pow10(ndigits) - lo);
				value = lo + raw % span;
			end else begin
				ndigits = $urandom_range(1, NUM_DIGITS - 1);
				value = pow10(ndigits) + 64'($urandom_range(0, 2)) - 64'd1;
			end
			send_value(value);
		end
		s_tvalid <= 1'b0;

		// Drain the outstanding digits, then watch for stray output.
		while (sb.pending_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d values (%0d directed, %0d with twenty digits) into %0d digit items",
			sb.values_noted, directed.size(), sb.twenty_digit_values, sb.digits_checked);
		$display("Mismatches and unexpected items: %0d", sb.errors);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/u64da_pkg.sv
rtl/u64da_dabble.sv
rtl/uint64_to_decimal_ascii.sv
rtl/u64da_checker.sv
tb/uint64_to_decimal_ascii_tb.sv
